@@ rtl/polynomial_evaluator_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the polynomial evaluator
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_EVALUATOR_ASSERT_SVH
`define POLYNOMIAL_EVALUATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define PE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define PE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/polyev_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyev_pkg
// Widths, command codes and the cell-to-cell bus of the polynomial evaluator.
// ----------------------------------------------------------------------------
package polyev_pkg;

    // Coefficient registers
    localparam int COEF_W    = 32;
    localparam int NUM_COEFS = 8;
    localparam int CFG_IDX_W = $clog2(NUM_COEFS);

    // Datapath widths
    localparam int PT_W    = 32;   // Q16.16 point
    localparam int ACC_W   = 48;   // Q32.16 accumulator
    localparam int SPLIT_W = 24;   // accumulator split for the partial products
    localparam int KC_W    = 36;   // derived coefficient (derivative needs 35 bits)

    // Commands
    localparam int CMD_W = 2;
    typedef logic [CMD_W-1:0] t_cmd;
    localparam t_cmd CMD_VALUE = 2'd0;
    localparam t_cmd CMD_DERIV = 2'd1;
    localparam t_cmd CMD_INTEG = 2'd2;
    localparam t_cmd CMD_NONE  = 2'd3;

    // Saturation limits
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // One item in flight: lane a evaluates at point_a, lane b at point_b
    typedef struct packed {
        logic                     valid;
        t_cmd                     cmd;
        logic signed [PT_W-1:0]   pa;
        logic signed [PT_W-1:0]   pb;
        logic signed [ACC_W-1:0]  acc_a;
        logic signed [ACC_W-1:0]  acc_b;
        logic                     ov_a;
        logic                     ov_b;
    } t_cell_bus;

endpackage

@@ rtl/polyev_coeff.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyev_coeff
// Builds the per-position coefficient sets for value, derivative and
// integral from the coefficient registers; integral terms use a
// reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module polyev_coeff
    import polyev_pkg::*;
#(
    parameter int MAX_DEGREE = 7
)
(
    input  logic                    i_clk,
    input  logic signed [COEF_W-1:0] i_coef    [NUM_COEFS],
    output logic signed [KC_W-1:0]  o_k_value [MAX_DEGREE+2],
    output logic signed [KC_W-1:0]  o_k_deriv [MAX_DEGREE+2],
    output logic signed [KC_W-1:0]  o_k_integ [MAX_DEGREE+2]
);

    localparam int NPOS    = MAX_DEGREE + 2;
    localparam int RECIP_W = COEF_W + 1;
    localparam int PROD_W  = COEF_W + RECIP_W;

    genvar p;
    generate
        for (p = 0; p < NPOS; p++) begin : g_pos

            // Plain coefficient of x^p
            if (p <= MAX_DEGREE) begin : g_val
                logic signed [KC_W-1:0] r_k;
                always_ff @(posedge i_clk) begin
                    r_k <= KC_W'(i_coef[p]);
                end
                assign o_k_value[p] = r_k;
            end else begin : g_val_zero
                assign o_k_value[p] = '0;
            end

            // Derivative term (p+1) * c[p+1]
            if (p < MAX_DEGREE) begin : g_der
                localparam logic signed [KC_W-1:0] Mul = KC_W'(p + 1);
                logic signed [KC_W-1:0] r_k;
                always_ff @(posedge i_clk) begin
                    r_k <= KC_W'(i_coef[p+1]) * Mul;
                end
                assign o_k_deriv[p] = r_k;
            end else begin : g_der_zero
                assign o_k_deriv[p] = '0;
            end

            // Integral term floor(c[p-1] / p), rounded toward minus infinity
            if (p >= 1) begin : g_int
                localparam logic [RECIP_W-1:0] Recip = RECIP_W'((64'd1 << COEF_W) / p);
                localparam logic [RECIP_W-1:0] Dval  = RECIP_W'(p);
                logic [COEF_W-1:0]  w_mag;
                logic               r_neg;
                logic [COEF_W-1:0]  r_mag;
                logic [PROD_W-1:0]  r_prod;
                logic [RECIP_W-1:0] w_q0;
                logic [RECIP_W-1:0] w_rem0;
                logic [RECIP_W-1:0] w_q;
                logic [RECIP_W-1:0] w_rem;
                logic [KC_W-1:0]    w_qn;
                logic [KC_W-1:0]    n_k;
                logic signed [KC_W-1:0] r_k;

                assign w_mag = i_coef[p-1][COEF_W-1] ? COEF_W'(-i_coef[p-1])
                                                      : COEF_W'(i_coef[p-1]);

                // Stage A: magnitude times reciprocal
                always_ff @(posedge i_clk) begin
                    r_neg  <= i_coef[p-1][COEF_W-1];
                    r_mag  <= w_mag;
                    r_prod <= w_mag * Recip;
                end

                // Stage B: estimate is low by at most one, fix with the remainder
                always_comb begin
                    w_q0   = r_prod[PROD_W-1:COEF_W];
                    w_rem0 = RECIP_W'(r_mag) - RECIP_W'(w_q0 * Dval);
                    if (w_rem0 >= Dval) begin
                        w_q   = w_q0 + RECIP_W'(1);
                        w_rem = w_rem0 - Dval;
                    end else begin
                        w_q   = w_q0;
                        w_rem = w_rem0;
                    end
                    w_qn = KC_W'(w_q) + KC_W'(w_rem != '0);
                    n_k  = r_neg ? -w_qn : KC_W'(w_q);
                end

                always_ff @(posedge i_clk) begin
                    r_k <= n_k;
                end
                assign o_k_integ[p] = r_k;
            end else begin : g_int_zero
                assign o_k_integ[p] = '0;
            end
        end
    endgenerate

endmodule

@@ rtl/polyev_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyev_cell
// One Horner step on two lanes: acc = sat48(floor(acc * x / 2^F) + k).
// Stage 1 forms two partial products, stage 2 adds and saturates.
// ----------------------------------------------------------------------------
module polyev_cell
    import polyev_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic signed [KC_W-1:0] i_k_value,
    input  logic signed [KC_W-1:0] i_k_deriv,
    input  logic signed [KC_W-1:0] i_k_integ,
    input  t_cell_bus              i_bus,
    output t_cell_bus              o_bus
);

    localparam int NLANE = 2;
    localparam int PH_W  = SPLIT_W + PT_W;
    localparam int PL_W  = SPLIT_W + 1 + PT_W;
    localparam int SHL   = SPLIT_W - FRAC_BITS;
    localparam int SUM_W = PH_W + SHL + 2;

    t_cell_bus r_s1;
    t_cell_bus r_s2;
    t_cell_bus n_s2;

    logic signed [ACC_W-1:0] w_acc [NLANE];
    logic signed [PT_W-1:0]  w_x   [NLANE];
    logic signed [PH_W-1:0]  n_ph  [NLANE];
    logic signed [PL_W-1:0]  n_pl  [NLANE];
    logic signed [PH_W-1:0]  r_ph  [NLANE];
    logic signed [PL_W-1:0]  r_pl  [NLANE];
    logic                    w_ov_in [NLANE];
    logic signed [ACC_W-1:0] n_acc [NLANE];
    logic                    n_ov  [NLANE];
    logic signed [KC_W-1:0]  w_k;

    assign w_acc[0]   = i_bus.acc_a;
    assign w_acc[1]   = i_bus.acc_b;
    assign w_x[0]     = i_bus.pa;
    assign w_x[1]     = i_bus.pb;
    assign w_ov_in[0] = r_s1.ov_a;
    assign w_ov_in[1] = r_s1.ov_b;

    // Coefficient for this position, per command
    always_comb begin
        unique case (r_s1.cmd)
            CMD_VALUE: w_k = i_k_value;
            CMD_DERIV: w_k = i_k_deriv;
            CMD_INTEG: w_k = i_k_integ;
            CMD_NONE:  w_k = '0;
        endcase
    end

    genvar l;
    generate
        for (l = 0; l < NLANE; l++) begin : g_lane
            logic signed [SPLIT_W-1:0] w_hi;
            logic signed [SPLIT_W:0]   w_lo;
            logic signed [SUM_W-1:0]   w_sum;
            logic                      w_in_range;

            // Partial products: signed upper half, unsigned lower half
            assign w_hi    = w_acc[l][ACC_W-1:SPLIT_W];
            assign w_lo    = {1'b0, w_acc[l][SPLIT_W-1:0]};
            assign n_ph[l] = w_hi * w_x[l];
            assign n_pl[l] = w_lo * w_x[l];

            // Recombine, drop the fraction, add coefficient, saturate
            assign w_sum = (SUM_W'(r_ph[l]) <<< SHL) + SUM_W'(r_pl[l] >>> FRAC_BITS)
                         + SUM_W'(w_k);
            assign w_in_range = (w_sum[SUM_W-1:ACC_W-1]
                                 == {(SUM_W-ACC_W+1){w_sum[SUM_W-1]}});

            always_comb begin
                if (w_in_range) begin
                    n_acc[l] = w_sum[ACC_W-1:0];
                end else begin
                    n_acc[l] = w_sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
                end
                n_ov[l] = w_ov_in[l] | ~w_in_range;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ph[l] <= n_ph[l];
                    r_pl[l] <= n_pl[l];
                end
            end
        end
    endgenerate

    always_comb begin
        n_s2       = r_s1;
        n_s2.acc_a = n_acc[0];
        n_s2.acc_b = n_acc[1];
        n_s2.ov_a  = n_ov[0];
        n_s2.ov_b  = n_ov[1];
    end

    // Stage registers; only valid is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else if (i_en) begin
            r_s1 <= i_bus;
            r_s2 <= n_s2;
        end
    end

    assign o_bus = r_s2;

endmodule

@@ rtl/polynomial_evaluator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_evaluator
// Fixed-point Horner evaluator for value, derivative and definite integral.
// ----------------------------------------------------------------------------
// Usage:
//   Coefficients c[0..7] (signed Q16.16) are written through the cfg channel,
//   one transfer per register at index i; o_cfg_ready is always high. An item
//   arriving the cycle after a write already sees the new coefficient.
//   Input channel: i_command, i_point_a, i_point_b transfer when i_in_valid is
//   high and o_in_stall is low. Each item gives exactly one result on the
//   output channel (o_value Q32.16, o_overflow), in order, transferred when
//   o_out_valid is high and i_out_stall is low.
//   Each item passes the input register, a chain of MAX_DEGREE+2 Horner
//   cells (two register stages each), a final stage and the output register.
//   Throughput: one item per cycle while o_in_stall is low.
//   Both integral bounds run side by side in two lanes of every cell.
//   When the receiver stalls, the finished result holds on the output and one
//   more lands in a skid register; then o_in_stall rises and the whole chain
//   freezes until the output frees up.
//   Reset clears all coefficients to zero and empties the pipeline.
// ----------------------------------------------------------------------------
`include "polynomial_evaluator_assert.svh"

module polynomial_evaluator
    import polyev_pkg::*;
#(
    parameter int MAX_DEGREE = 7,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [CMD_W-1:0]          i_command,
    input  logic signed [PT_W-1:0]    i_point_a,
    input  logic signed [PT_W-1:0]    i_point_b,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [ACC_W-1:0]   o_value,
    output logic                      o_overflow,
    // configuration channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic signed [COEF_W-1:0]  i_cfg_data
);

    localparam int NCELL = MAX_DEGREE + 2;

    logic signed [COEF_W-1:0] r_coef    [NUM_COEFS];
    logic signed [KC_W-1:0]   w_k_value [NCELL];
    logic signed [KC_W-1:0]   w_k_deriv [NCELL];
    logic signed [KC_W-1:0]   w_k_integ [NCELL];

    t_cell_bus                w_bus [NCELL+1];
    t_cell_bus                r_in;
    t_cell_bus                n_in;
    t_cell_bus                w_last;

    logic                     w_en;
    logic                     w_in_xfer;
    logic signed [ACC_W:0]    w_diff;
    logic signed [ACC_W-1:0]  n_fin_value;
    logic                     n_fin_ov;
    logic                     r_fin_valid;
    logic signed [ACC_W-1:0]  r_fin_value;
    logic                     r_fin_ov;
    logic                     w_fin_leave;
    logic                     w_out_free;
    logic                     r_out_valid;
    logic signed [ACC_W-1:0]  r_out_value;
    logic                     r_out_ov;
    logic                     r_skid_valid;
    logic signed [ACC_W-1:0]  r_skid_value;
    logic                     r_skid_ov;

    // Coefficient registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    polyev_coeff #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_coeff (
        .i_clk     (i_clk),
        .i_coef    (r_coef),
        .o_k_value (w_k_value),
        .o_k_deriv (w_k_deriv),
        .o_k_integ (w_k_integ)
    );

    // Pipeline advances whenever the skid register is empty
    assign w_en       = ~r_skid_valid;
    assign o_in_stall = r_skid_valid;
    assign w_in_xfer  = i_in_valid & ~o_in_stall;

    // Input register: both lanes start from a zero accumulator
    always_comb begin
        n_in.valid = w_in_xfer;
        n_in.cmd   = i_command;
        n_in.pa    = i_point_a;
        n_in.pb    = i_point_b;
        n_in.acc_a = '0;
        n_in.acc_b = '0;
        n_in.ov_a  = 1'b0;
        n_in.ov_b  = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in <= n_in;
        end
    end

    assign w_bus[0] = r_in;

    // Horner chain, top coefficient first
    genvar j;
    generate
        for (j = 0; j < NCELL; j++) begin : g_cell
            polyev_cell #(
                .FRAC_BITS (FRAC_BITS)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_en      (w_en),
                .i_k_value (w_k_value[NCELL-1-j]),
                .i_k_deriv (w_k_deriv[NCELL-1-j]),
                .i_k_integ (w_k_integ[NCELL-1-j]),
                .i_bus     (w_bus[j]),
                .o_bus     (w_bus[j+1])
            );
        end
    endgenerate

    assign w_last = w_bus[NCELL];

    // Final stage: F(b) - F(a) for the integral, lane a for value and derivative, zero for CMD_NONE
    assign w_diff = {w_last.acc_b[ACC_W-1], w_last.acc_b}
                  - {w_last.acc_a[ACC_W-1], w_last.acc_a};

    always_comb begin
        unique case (w_last.cmd)
            CMD_VALUE, CMD_DERIV: begin
                n_fin_value = w_last.acc_a;
                n_fin_ov    = w_last.ov_a;
            end
            CMD_INTEG: begin
                if (w_diff[ACC_W] == w_diff[ACC_W-1]) begin
                    n_fin_value = w_diff[ACC_W-1:0];
                    n_fin_ov    = w_last.ov_a | w_last.ov_b;
                end else begin
                    n_fin_value = w_diff[ACC_W] ? ACC_MIN : ACC_MAX;
                    n_fin_ov    = 1'b1;
                end
            end
            CMD_NONE: begin
                n_fin_value = '0;
                n_fin_ov    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (w_en) begin
            r_fin_valid <= w_last.valid;
            r_fin_value <= n_fin_value;
            r_fin_ov    <= n_fin_ov;
        end
    end

    // Output register with one skid entry
    assign w_out_free  = ~r_out_valid | ~i_out_stall;
    assign w_fin_leave = w_en & r_fin_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_value  <= r_skid_value;
                r_out_ov     <= r_skid_ov;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_fin_leave;
                if (w_fin_leave) begin
                    r_out_value <= r_fin_value;
                    r_out_ov    <= r_fin_ov;
                end
            end
        end else if (w_fin_leave) begin
            r_skid_valid <= 1'b1;
            r_skid_value <= r_fin_value;
            r_skid_ov    <= r_fin_ov;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_overflow  = r_out_ov;

    // Checks
    `PE_ASSERT_IMP(a_skid_needs_out, r_skid_valid, r_out_valid, "skid full with output empty")
    `PE_ASSERT_IMP(a_skid_fill, $rose(r_skid_valid), $past(r_out_valid && i_out_stall), "skid filled without a stalled output")
    `PE_ASSERT_NXT(a_fin_hold, r_fin_valid && !w_en, r_fin_valid, "result lost while pipeline frozen")
    `PE_ASSERT_NXT(a_unused_cmd, w_en && w_last.valid && w_last.cmd == CMD_NONE, r_fin_value == '0 && !r_fin_ov, "unused command gave a nonzero result")

endmodule

@@ tb/tb_polynomial_evaluator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polynomial_evaluator
// Self-checking bench for the fixed-point Horner evaluator. A short table of
// directed items runs first: reset state, coefficient and point extremes,
// saturation, the integral difference clamp, negative floor rounding and the
// unused command. Random phases follow, each with a fresh coefficient set
// and degree. Every result is scored in order against a typed value or a
// local model of the Q16.16 / Q32.16 datapath. Both sides idle in random
// bursts. One phase holds the output off long enough to back up the pipe,
// and one phase pauses the sender until the pipe is empty.
// ----------------------------------------------------------------------------
module tb_polynomial_evaluator;
    import polyev_pkg::*;

    localparam int MAX_DEGREE      = 7;
    localparam int FRAC_BITS       = 16;
    localparam int PIPE_LATENCY    = 2 * MAX_DEGREE + 6;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int LONG_HOLD       = 200;
    localparam int N_PHASES        = 16;
    localparam int ITEMS_PER_PHASE = 102;
    localparam int HOLD_PHASE      = 3;
    localparam int PAUSE_PHASE     = 6;
    localparam int DIR_ROWS        = 25;

    // One scored result
    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic                    ovf;
    } t_result;

    // Coefficient sets used by the directed table
    typedef enum int {
        SET_RESET,
        SET_ALL_MAX,
        SET_ALL_MIN,
        SET_CUBE_HI,
        SET_NEG_ODD,
        SET_QUAD,
        N_SETS
    } t_coef_set;

    typedef struct {
        t_coef_set               cset;
        t_cmd                    cmd;
        logic [PT_W-1:0]         pa;
        logic [PT_W-1:0]         pb;
        bit                      typed;
        logic signed [ACC_W-1:0] value;
        logic                    ovf;
    } t_dir_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    t_cmd                     i_command;
    logic signed [PT_W-1:0]   i_point_a;
    logic signed [PT_W-1:0]   i_point_b;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [ACC_W-1:0]  o_value;
    logic                     o_overflow;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic signed [COEF_W-1:0] i_cfg_data;

    // Bench copy of the coefficient registers and the next set to load
    logic signed [COEF_W-1:0] coef_mdl  [NUM_COEFS];
    logic signed [COEF_W-1:0] coef_next [NUM_COEFS];

    t_result result_q [$];
    t_result head;
    int      err_cnt      = 0;
    int      tx_gap_pct   = 0;
    int      rx_stall_pct = 0;
    bit      hold_req     = 1'b0;

    logic signed [COEF_W-1:0] coef_sets [N_SETS][NUM_COEFS] = '{
        '{default: 32'h0000_0000},
        '{default: 32'h7FFF_FFFF},
        '{default: 32'h8000_0000},
        '{32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{-7, -1, -5, -3, -11, -13, -17, 3},
        '{32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0}
    };

    // Expected values are typed in only where they are obvious
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{SET_RESET,   CMD_VALUE, 32'h8000_0000, 32'h0000_0000, 1, 48'h0, 1'b0},
        '{SET_RESET,   CMD_DERIV, 32'h7FFF_FFFF, 32'h0000_0000, 1, 48'h0, 1'b0},
        '{SET_RESET,   CMD_INTEG, 32'h8000_0000, 32'h7FFF_FFFF, 1, 48'h0, 1'b0},
        '{SET_RESET,   CMD_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 48'h0, 1'b0},
        '{SET_ALL_MAX, CMD_VALUE, 32'h0000_0000, 32'h0000_0000, 1,
          48'h0000_7FFF_FFFF, 1'b0},
        '{SET_ALL_MAX, CMD_VALUE, 32'h7FFF_FFFF, 32'h0000_0000, 1, ACC_MAX, 1'b1},
        '{SET_ALL_MAX, CMD_VALUE, 32'h8000_0000, 32'h0000_0000, 0, 48'h0, 1'b0},
        '{SET_ALL_MAX, CMD_DERIV, 32'h0000_0000, 32'h0000_0000, 1,
          48'h0000_7FFF_FFFF, 1'b0},
        '{SET_ALL_MAX, CMD_DERIV, 32'h7FFF_FFFF, 32'h0000_0000, 0, 48'h0, 1'b0},
        '{SET_ALL_MAX, CMD_INTEG, 32'h0000_0000, 32'h0000_0000, 1, 48'h0, 1'b0},
        '{SET_ALL_MAX, CMD_INTEG, 32'h8000_0000, 32'h7FFF_FFFF, 0, 48'h0, 1'b0},
        '{SET_ALL_MAX, CMD_NONE,  32'h7FFF_FFFF, 32'h8000_0000, 1, 48'h0, 1'b0},
        '{SET_ALL_MIN, CMD_VALUE, 32'h0000_0000, 32'h0000_0000, 1,
          48'hFFFF_8000_0000, 1'b0},
        '{SET_ALL_MIN, CMD_VALUE, 32'h7FFF_FFFF, 32'h0000_0000, 0, 48'h0, 1'b0},
        '{SET_ALL_MIN, CMD_VALUE, 32'h8000_0000, 32'h0000_0000, 0, 48'h0, 1'b0},
        '{SET_ALL_MIN, CMD_DERIV, 32'hFFFF_0000, 32'h0000_0000, 0, 48'h0, 1'b0},
        '{SET_ALL_MIN, CMD_INTEG, 32'h7FFF_FFFF, 32'h8000_0000, 0, 48'h0, 1'b0},
        '{SET_CUBE_HI, CMD_INTEG, 32'hFFD0_0000, 32'h0030_0000, 0, 48'h0, 1'b0},
        '{SET_CUBE_HI, CMD_INTEG, 32'h0030_0000, 32'hFFD0_0000, 0, 48'h0, 1'b0},
        '{SET_CUBE_HI, CMD_VALUE, 32'h0001_0000, 32'h0000_0000, 0, 48'h0, 1'b0},
        '{SET_NEG_ODD, CMD_INTEG, 32'h0000_0000, 32'h0001_0000, 0, 48'h0, 1'b0},
        '{SET_NEG_ODD, CMD_DERIV, 32'hFFFF_FFFF, 32'h0000_0000, 0, 48'h0, 1'b0},
        '{SET_NEG_ODD, CMD_VALUE, 32'h0000_0001, 32'h0000_0000, 0, 48'h0, 1'b0},
        '{SET_QUAD,    CMD_VALUE, 32'h0003_0000, 32'h0000_0000, 0, 48'h0, 1'b0},
        '{SET_QUAD,    CMD_DERIV, 32'h0001_8000, 32'h0000_0000, 0, 48'h0, 1'b0}
    };

    polynomial_evaluator #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_point_a   (i_point_a),
        .i_point_b   (i_point_b),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value),
        .o_overflow  (o_overflow),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Horner's rule from coefficient top down, each step saturated to 48 bits
    function automatic logic signed [ACC_W-1:0] horner_eval(
        input logic [NUM_COEFS:0][KC_W-1:0] kc,
        input int                           top,
        input logic signed [PT_W-1:0]       x,
        inout logic                         ov
    );
        logic signed [ACC_W-1:0]      acc;
        logic signed [ACC_W+PT_W+1:0] wide;
        acc = '0;
        for (int i = top; i >= 0; i--) begin
            wide = acc * x;
            wide = (wide >>> FRAC_BITS) + $signed(kc[i]);
            if (wide > ACC_MAX) begin
                acc = ACC_MAX;
                ov  = 1'b1;
            end else if (wide < ACC_MIN) begin
                acc = ACC_MIN;
                ov  = 1'b1;
            end else begin
                acc = wide[ACC_W-1:0];
            end
        end
        return acc;
    endfunction

    // Value, derivative or definite integral from the bench coefficient copy
    function automatic t_result predict_result(
        input t_cmd                   cmd,
        input logic signed [PT_W-1:0] pa,
        input logic signed [PT_W-1:0] pb
    );
        logic [NUM_COEFS:0][KC_W-1:0] kc;
        logic signed [ACC_W-1:0]      fa;
        logic signed [ACC_W-1:0]      fb;
        logic signed [ACC_W+1:0]      diff;
        longint                       q;
        longint                       d;
        logic                         ov;
        t_result                      r;
        kc = '0;
        ov = 1'b0;
        r  = '0;
        case (cmd)
            CMD_VALUE: begin
                for (int i = 0; i <= MAX_DEGREE; i++) begin
                    q     = coef_mdl[i];
                    kc[i] = q[KC_W-1:0];
                end
                r.value = horner_eval(kc, MAX_DEGREE, pa, ov);
            end
            CMD_DERIV: begin
                for (int i = 0; i < MAX_DEGREE; i++) begin
                    q     = coef_mdl[i+1];
                    q     = q * (i + 1);
                    kc[i] = q[KC_W-1:0];
                end
                r.value = horner_eval(kc, MAX_DEGREE - 1, pa, ov);
            end
            CMD_INTEG: begin
                // antiderivative terms, divided with rounding toward minus infinity
                for (int i = 0; i <= MAX_DEGREE; i++) begin
                    d = i + 1;
                    q = coef_mdl[i];
                    if (q < 0 && (q % d) != 0)
                        q = q / d - 1;
                    else
                        q = q / d;
                    kc[i+1] = q[KC_W-1:0];
                end
                fb   = horner_eval(kc, MAX_DEGREE + 1, pb, ov);
                fa   = horner_eval(kc, MAX_DEGREE + 1, pa, ov);
                diff = fb - fa;
                if (diff > ACC_MAX) begin
                    r.value = ACC_MAX;
                    ov      = 1'b1;
                end else if (diff < ACC_MIN) begin
                    r.value = ACC_MIN;
                    ov      = 1'b1;
                end else begin
                    r.value = diff[ACC_W-1:0];
                end
            end
            default: r.value = '0;
        endcase
        r.ovf = ov;
        return r;
    endfunction

    function automatic logic [PT_W-1:0] rand_point();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            2: return $signed($urandom()) >>> $urandom_range(8, 20);
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: return $urandom();
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            default: return $signed($urandom()) >>> $urandom_range(4, 24);
        endcase
    endfunction

    function automatic t_cmd rand_cmd();
        return ($urandom_range(0, 9) == 0) ? CMD_NONE : t_cmd'($urandom_range(0, 2));
    endfunction

    // Offer one item, hold it until the transfer, then record its expectation
    task automatic send_item(
        input t_cmd            cmd,
        input logic [PT_W-1:0] pa,
        input logic [PT_W-1:0] pb,
        input bit              use_fixed,
        input t_result         fixed_res
    );
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_point_a  <= pa;
        i_point_b  <= pb;
        do @(posedge i_clk); while (o_in_stall);
        result_q.push_back(use_fixed ? fixed_res : predict_result(cmd, pa, pb));
    endtask

    // Random sender gap
    task automatic tx_gap();
        if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (result_q.size() != 0);
    endtask

    // Load coef_next into the block once the pipe is empty
    task automatic load_coefs();
        drain_results();
        for (int i = 0; i < NUM_COEFS; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= coef_next[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            coef_mdl[i] = coef_next[i];
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Output stall: random bursts, or one long hold on request
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Score each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_q.size() == 0) begin
                $display("%t unexpected result: value %h overflow %b",
                         $realtime, o_value, o_overflow);
                err_cnt++;
            end else begin
                head = result_q.pop_front();
                if (o_value !== head.value) begin
                    $display("%t value mismatch: expected %h actual %h",
                             $realtime, head.value, o_value);
                    err_cnt++;
                end
                if (o_overflow !== head.ovf) begin
                    $display("%t overflow mismatch: expected %b actual %b",
                             $realtime, head.ovf, o_overflow);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any transfer
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        t_coef_set cur_set;
        t_result   fix;
        int        deg;
        cur_set = SET_RESET;
        for (int i = 0; i < NUM_COEFS; i++)
            coef_mdl[i] = '0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_command   <= CMD_VALUE;
        i_point_a   <= '0;
        i_point_b   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_tab[r].cset != cur_set) begin
                for (int i = 0; i < NUM_COEFS; i++)
                    coef_next[i] = coef_sets[dir_tab[r].cset][i];
                load_coefs();
                cur_set = dir_tab[r].cset;
            end
            fix.value = dir_tab[r].value;
            fix.ovf   = dir_tab[r].ovf;
            send_item(dir_tab[r].cmd, dir_tab[r].pa, dir_tab[r].pb, dir_tab[r].typed, fix);
            tx_gap();
        end

        // random phases, each with its own coefficients and degree
        for (int ph = 0; ph < N_PHASES; ph++) begin
            deg = $urandom_range(0, MAX_DEGREE);
            for (int i = 0; i < NUM_COEFS; i++)
                coef_next[i] = (i <= deg) ? rand_coef() : '0;
            load_coefs();
            if (ph >= N_PHASES - 2) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else begin
                tx_gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                rx_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            end
            // back the pipe up: output held off while items keep coming
            if (ph == HOLD_PHASE) begin
                tx_gap_pct = 0;
                hold_req   = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2)
                    drain_results();
                send_item(rand_cmd(), rand_point(), rand_point(), 1'b0, '0);
                tx_gap();
            end
        end

        drain_results();
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
